### rtl/core/sla_pkg.sv
// Types and constants shared by the serial line assembler modules.
package sla_pkg;

	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_REARM = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [7:0] CH_LF = 8'h0a;
	localparam logic [7:0] CH_CR = 8'h0d;

	localparam logic [7:0] REJECT_MAX = 8'hff;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
		logic       rx_fault;
		logic [5:0] read_index;
	} item_t;

	typedef struct packed {
		logic       line_ready;
		logic       event_pending;
		logic [6:0] char_count;
		logic [7:0] error_count;
		logic       accepting;
		logic [7:0] read_data;
		logic       line_present;
	} result_t;

	typedef struct packed {
		logic       line_ready;
		logic       event_pending;
		logic [6:0] char_count;
		logic [7:0] error_count;
		logic       accepting;
		logic       line_present;
		logic       read_sel;
	} status_t;

endpackage

### rtl/core/sla_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
interface sla_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

### rtl/core/serial_line_assembler_top.sv
// Top level of the serial line assembler: input register, line logic, store and result register.
// A beat is held in item_s1, then its status in status_s2 when the result stage advances.
// Throughput: one beat per cycle unless result.ready stalls; the only loop is the state update.
// Reset clears the count, reject counter and event flag and enables acceptance.
// The line store is not cleared by reset; entries are undefined until written.
module serial_line_assembler_top #(
	parameter int LINE_DEPTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	sla_stream_if.sink   item,
	sla_stream_if.source result
);

	localparam int AW = $clog2(LINE_DEPTH);

	sla_pkg::item_t   item_s1;
	logic             valid_s1;
	sla_pkg::status_t status_d;
	sla_pkg::status_t status_s2;
	logic             valid_s2;
	logic             advance;
	logic             step;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       ram_q;

	assign advance    = !valid_s2 || result.ready;
	assign item.ready = !valid_s1 || advance;
	assign step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
		if (step) begin
			status_s2 <= status_d;
		end
	end

	sla_ctrl #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.it      (item_s1),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.status  (status_d)
	);

	sla_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (step && wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (step),
		.raddr (rd_addr),
		.q     (ram_q)
	);

	assign result.valid = valid_s2;

	always_comb begin
		result.data.line_ready    = status_s2.line_ready;
		result.data.event_pending = status_s2.event_pending;
		result.data.char_count    = status_s2.char_count;
		result.data.error_count   = status_s2.error_count;
		result.data.accepting     = status_s2.accepting;
		result.data.read_data     = status_s2.read_sel ? ram_q : 8'd0;
		result.data.line_present  = status_s2.line_present;
	end

endmodule

### rtl/core/sla_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			q <= mem_q[raddr];
		end
	end

endmodule

### rtl/core/sla_ctrl.sv
// Line state registers and the per-beat update of count, enable, reject and event.
module sla_ctrl #(
	parameter int LINE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  sla_pkg::item_t                it,
	output logic                          wr_en,
	output logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
	output logic [7:0]                    wr_data,
	output logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
	output sla_pkg::status_t              status
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);

	logic [CW-1:0] fill_q, fill_d;
	logic          take_q, take_d;
	logic [7:0]    reject_q, reject_d;
	logic          event_q, event_d;
	logic          ready_d;
	logic          is_char;
	logic          can_take;
	logic          is_cr;
	logic [31:0]   fill_wide;

	assign is_char  = (it.mode == sla_pkg::MODE_BYTE) && !it.rx_fault
		&& (it.rx_byte != sla_pkg::CH_LF);
	assign is_cr    = (it.rx_byte == sla_pkg::CH_CR);
	assign can_take = take_q && (reject_q == 8'd0) && (fill_q < CW'(LINE_DEPTH));

	always_comb begin
		fill_d   = fill_q;
		take_d   = take_q;
		reject_d = reject_q;
		event_d  = event_q;
		ready_d  = 1'b0;
		wr_en    = 1'b0;
		wr_data  = it.rx_byte;
		case (it.mode)
			sla_pkg::MODE_BYTE: begin
				if (is_char) begin
					if (can_take) begin
						wr_en = 1'b1;
						if (is_cr) begin
							wr_data = 8'd0;
							take_d  = 1'b0;
							event_d = 1'b1;
							ready_d = 1'b1;
						end else begin
							fill_d = CW'(fill_q + 1'b1);
						end
					end else begin
						if (reject_q != sla_pkg::REJECT_MAX) begin
							reject_d = reject_q + 8'd1;
						end
						fill_d = '0;
						if (is_cr) begin
							reject_d = 8'd0;
							take_d   = 1'b1;
						end
					end
				end
			end
			sla_pkg::MODE_REARM: begin
				fill_d = '0;
				take_d = 1'b1;
			end
			sla_pkg::MODE_CLEAR: begin
				event_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign wr_addr = AW'(fill_q);
	assign rd_addr = AW'(it.read_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			take_q   <= 1'b1;
			reject_q <= 8'd0;
			event_q  <= 1'b0;
		end else if (step) begin
			fill_q   <= fill_d;
			take_q   <= take_d;
			reject_q <= reject_d;
			event_q  <= event_d;
		end
	end

	assign fill_wide = 32'(fill_d);

	always_comb begin
		status.line_ready    = ready_d;
		status.event_pending = event_d;
		status.char_count    = fill_wide[6:0];
		status.error_count   = reject_d;
		status.accepting     = take_d;
		status.line_present  = (fill_d != '0);
		status.read_sel      = (it.mode == sla_pkg::MODE_READ)
			&& (32'(it.read_index) < 32'(LINE_DEPTH));
	end

endmodule

### rtl/core/sla_chk.sv
// Port-level assertions for the serial line assembler, bound to its top level.
module sla_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input sla_pkg::result_t  out_data
);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("Stalled result beat changed or dropped.");

	a_line_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.line_ready |-> !out_data.accepting
			&& out_data.event_pending && (out_data.error_count == 8'd0))
		else $error("Completed line without closing acceptance or raising the event.");

	a_reject_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.error_count != 8'd0) |-> (out_data.char_count == 7'd0)
			&& !out_data.line_present)
		else $error("Characters counted while rejects are pending.");

	a_ready_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.line_ready |-> (out_data.read_data == 8'd0))
		else $error("Read data shown on a line completion beat.");

endmodule

bind serial_line_assembler_top sla_chk u_sla_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
